/* design/pncm_pkg.sv */
// shared types and constants for the nearest palette colour search
package pncm_pkg;

    localparam int LEVEL_W         = 8;
    localparam int INDEX_W         = 8;
    localparam int COLOUR_W        = 3 * LEVEL_W;
    localparam int SQUARE_W        = 2 * LEVEL_W;
    localparam int DIST_W          = SQUARE_W + 2;
    localparam int PALETTE_ENTRIES_DEF = 256;

    typedef logic [LEVEL_W-1:0]  t_level;
    typedef logic [INDEX_W-1:0]  t_index;
    typedef logic [COLOUR_W-1:0] t_colour;
    typedef logic [SQUARE_W-1:0] t_square;
    typedef logic [DIST_W-1:0]   t_dist;

    // item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam t_colour BLACK_COLOUR = '0;
    localparam t_colour WHITE_COLOUR = '1;

    // starting bound of the search, above every reachable distance
    localparam t_dist DIST_START = '1;

endpackage

/* design/palette_nearest_colour_match_top.sv */
// nearest palette colour search: palette store, scan sequencer, output register
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  input    | i_valid / o_stall  | i_kind, i_entry_index, i_red/green/blue_level
//  output   | o_valid / i_stall  | o_match_index
//
// a query walks the palette one entry per cycle through the ram read port and the
// distance unit, stopping at the last entry or earlier when an exact match is found.
// reset clears the per-entry valid bits, so entries read as black until written;
// entry 0 stays black and the last entry stays white. the result sits in an output
// register, so a new transaction is taken while it waits on i_stall.
module palette_nearest_colour_match_top #(
    parameter  int PALETTE_ENTRIES = pncm_pkg::PALETTE_ENTRIES_DEF,
    localparam int AW              = $clog2(PALETTE_ENTRIES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_kind,
    input  pncm_pkg::t_index  i_entry_index,
    input  pncm_pkg::t_level  i_red_level,
    input  pncm_pkg::t_level  i_green_level,
    input  pncm_pkg::t_level  i_blue_level,
    output logic              o_valid,
    input  logic              i_stall,
    output pncm_pkg::t_index  o_match_index
);
    import pncm_pkg::*;

    localparam int CNT_W = AW + 1;
    localparam logic [AW-1:0]    LAST_IDX  = AW'(PALETTE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] ENTRY_CNT = CNT_W'(PALETTE_ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_issue, n_issue;
    t_colour            r_query, n_query;
    t_dist              r_best, n_best;
    logic [AW-1:0]      r_best_idx, n_best_idx;
    logic               r_p1_valid, n_p1_valid;
    logic               r_p2_valid, n_p2_valid;
    logic               r_p3_valid, n_p3_valid;
    logic [AW-1:0]      r_p1_idx, r_p2_idx, r_p3_idx;
    logic               r_p1_white, r_p1_black;
    logic               r_out_valid, n_out_valid;
    logic [AW-1:0]      r_out_idx, n_out_idx;
    logic [PALETTE_ENTRIES-1:0] r_live;

    logic               in_accept;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    t_colour            in_colour;
    logic               issue;
    t_colour            ram_rdata;
    t_colour            entry_colour;
    t_dist              entry_dist;
    logic               better;
    t_dist              cmp_best;
    logic               finish;

    // input transaction and palette write decode
    assign o_stall   = (r_state != S_IDLE);
    assign in_accept = i_valid && !o_stall;
    assign in_colour = {i_red_level, i_green_level, i_blue_level};
    assign wr_addr   = i_entry_index[AW-1:0];
    assign wr_en     = in_accept && (i_kind == KIND_WRITE) && (i_entry_index != '0)
                       && ({1'b0, i_entry_index} < (INDEX_W + 1)'(PALETTE_ENTRIES - 1));

    // scan address issue
    assign issue = (r_state == S_SCAN) && (r_issue < ENTRY_CNT) && !finish;

    pncm_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (in_colour),
        .i_rd_en   (issue),
        .i_rd_addr (r_issue[AW-1:0]),
        .o_rd_data (ram_rdata)
    );

    // fixed end entries and never written entries
    always_comb begin
        priority if (r_p1_white) begin
            entry_colour = WHITE_COLOUR;
        end else if (r_p1_black) begin
            entry_colour = BLACK_COLOUR;
        end else begin
            entry_colour = ram_rdata;
        end
    end

    pncm_dist u_dist (
        .i_clk   (i_clk),
        .i_entry (entry_colour),
        .i_query (r_query),
        .o_dist  (entry_dist)
    );

    // compare against the running best, strict less keeps the lowest index on ties
    assign better   = r_p3_valid && (entry_dist < r_best);
    assign cmp_best = better ? entry_dist : r_best;
    assign finish   = (r_state == S_SCAN) && r_p3_valid
                      && ((cmp_best == '0) || (r_p3_idx == LAST_IDX));

    // per-entry valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= '0;
        end else if (wr_en) begin
            r_live[wr_addr] <= 1'b1;
        end
    end

    // index and entry select pipeline alongside the distance unit
    always_ff @(posedge i_clk) begin
        r_p1_idx   <= r_issue[AW-1:0];
        r_p1_white <= (r_issue[AW-1:0] == LAST_IDX);
        r_p1_black <= (r_issue[AW-1:0] == '0) || !r_live[r_issue[AW-1:0]];
        r_p2_idx   <= r_p1_idx;
        r_p3_idx   <= r_p2_idx;
    end

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_issue     = r_issue;
        n_query     = r_query;
        n_best      = r_best;
        n_best_idx  = r_best_idx;
        n_p1_valid  = issue;
        n_p2_valid  = r_p1_valid && !finish;
        n_p3_valid  = r_p2_valid && !finish;
        n_out_valid = r_out_valid && i_stall;
        n_out_idx   = r_out_idx;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept && (i_kind == KIND_QUERY)) begin
                    n_state    = S_SCAN;
                    n_issue    = '0;
                    n_query    = in_colour;
                    n_best     = DIST_START;
                    n_best_idx = '0;
                end
            end
            S_SCAN: begin
                if (issue) begin
                    n_issue = r_issue + CNT_W'(1);
                end
                if (better) begin
                    n_best     = entry_dist;
                    n_best_idx = r_p3_idx;
                end
                if (finish) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = r_best_idx;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= '0;
            r_query     <= '0;
            r_best      <= DIST_START;
            r_best_idx  <= '0;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_p3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_idx   <= '0;
        end else begin
            r_state     <= n_state;
            r_issue     <= n_issue;
            r_query     <= n_query;
            r_best      <= n_best;
            r_best_idx  <= n_best_idx;
            r_p1_valid  <= n_p1_valid;
            r_p2_valid  <= n_p2_valid;
            r_p3_valid  <= n_p3_valid;
            r_out_valid <= n_out_valid;
            r_out_idx   <= n_out_idx;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_match_index = INDEX_W'(r_out_idx);

    // finishing a query always loads the output register
    a_fin_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && (!r_out_valid || !i_stall)) |=> o_valid)
        else $error("finished query did not reach the output register");

    // the running best never grows during a scan
    a_best_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && $past(r_state == S_SCAN)) |-> (r_best <= $past(r_best)))
        else $error("running best distance increased");

    // no entry is in flight while idle
    a_pipe_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !(r_p1_valid || r_p2_valid || r_p3_valid))
        else $error("distance pipeline busy while idle");

    // the issue counter never passes the palette size
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issue <= ENTRY_CNT)
        else $error("scan issued beyond the last entry");

endmodule

/* design/pncm_ram.sv */
// generic single write port, single read port ram with registered read data
module pncm_ram #(
    parameter  int WIDTH = 24,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/pncm_dist.sv */
// two-stage squared euclidean distance unit shared by every entry of a scan
module pncm_dist (
    input  logic             i_clk,
    input  pncm_pkg::t_colour i_entry,
    input  pncm_pkg::t_colour i_query,
    output pncm_pkg::t_dist   o_dist
);
    import pncm_pkg::*;

    t_square r_sq [3];
    t_dist   r_dist;

    // per component absolute difference and square
    for (genvar k = 0; k < 3; k++) begin : g_lane
        t_level a_lvl;
        t_level b_lvl;
        t_level diff;

        assign a_lvl = i_entry[k*LEVEL_W +: LEVEL_W];
        assign b_lvl = i_query[k*LEVEL_W +: LEVEL_W];
        assign diff  = (a_lvl > b_lvl) ? (a_lvl - b_lvl) : (b_lvl - a_lvl);

        always_ff @(posedge i_clk) begin
            r_sq[k] <= SQUARE_W'(diff) * SQUARE_W'(diff);
        end
    end

    // sum of the three squares
    always_ff @(posedge i_clk) begin
        r_dist <= DIST_W'(r_sq[0]) + DIST_W'(r_sq[1]) + DIST_W'(r_sq[2]);
    end

    assign o_dist = r_dist;

endmodule
